### hw/rtl/tccu_pkg.sv
// Shared types, codes and constants of the text console cursor engine.
package tccu_pkg;

   // Store geometry
   localparam int MAX_COLS  = 128;
   localparam int MAX_ROWS  = 64;
   localparam int TAB_WIDTH = 8;
   localparam int CELLS     = MAX_COLS * MAX_ROWS;
   localparam int CELL_AW   = $clog2(CELLS);

   // Command codes
   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Control characters
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;

   // Register indexes
   localparam logic [1:0] CSR_COLUMNS = 2'd0;
   localparam logic [1:0] CSR_ROWS    = 2'd1;
   localparam logic [1:0] CSR_BLANK   = 2'd2;

   // Register reset values
   localparam logic [7:0] COLUMNS_RESET = 8'd80;
   localparam logic [6:0] ROWS_RESET    = 7'd25;
   localparam logic [7:0] BLANK_RESET   = 8'd7;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_CR,
      OP_LF,
      OP_BS,
      OP_TAB,
      OP_PRINT,
      OP_CLEAR,
      OP_READ
   } op_kind_type;

   typedef struct packed {
      op_kind_type  kind;
      logic [7:0]   ch;
      logic [7:0]   attr;
      logic [12:0]  cell_index;
   } op_type;

   typedef struct packed {
      logic   empty;
      op_type op;
   } opq_status_type;

   typedef struct packed {
      logic [7:0]  cols;
      logic [6:0]  rows;
      logic [7:0]  blank_attr;
      logic [13:0] total;
      logic [12:0] moved;
   } geom_type;

   typedef struct packed {
      logic [6:0]  cursor_col;
      logic [5:0]  cursor_row;
      logic [12:0] cursor_offset;
      logic [7:0]  cell_char;
      logic [7:0]  cell_attr;
   } result_type;

   typedef struct packed {
      logic       push;
      result_type res;
   } rsp_write_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADDR,
      ST_EXEC,
      ST_TAB,
      ST_WRAP,
      ST_SCROLL,
      ST_BLANK,
      ST_CLEAR,
      ST_READ,
      ST_OFFSET
   } back_state_type;

endpackage

### hw/rtl/tccu_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
module tccu_front import tccu_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   output logic           full,
   input  logic [1:0]     cmd,
   input  logic [7:0]     ch,
   input  logic [7:0]     attr,
   input  logic [12:0]    cell_index,
   input  logic           pop,
   output opq_status_type status
);

   op_type      q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   op_kind_type kind;
   op_type      entry;
   logic        do_push;
   logic        do_pop;

   // Decode the item into the operation the back end carries out.
   always_comb begin
      case (cmd)
         CMD_PUT: begin
            case (ch)
               CH_NUL:  kind = OP_NOP;
               CH_CR:   kind = OP_CR;
               CH_LF:   kind = OP_LF;
               CH_BS:   kind = OP_BS;
               CH_TAB:  kind = OP_TAB;
               default: kind = OP_PRINT;
            endcase
         end
         CMD_CLEAR: kind = OP_CLEAR;
         CMD_READ:  kind = OP_READ;
         default:   kind = OP_NOP;
      endcase
   end

   assign entry = '{kind: kind, ch: ch, attr: attr, cell_index: cell_index};

   assign full    = (count_ff == 2'd2);
   assign do_push = push && !full;
   assign do_pop  = pop && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

   assign status.empty = (count_ff == 2'd0);
   assign status.op    = q_ff[rd_ptr_ff];

endmodule

### hw/rtl/tccu_back.sv
// Back end: cursor, screen store and the sequencer that carries out operations.
module tccu_back import tccu_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  geom_type       geom,
   input  opq_status_type opq,
   output logic           opq_pop,
   input  logic           rsp_full,
   output rsp_write_type  rsp_wr
);

   back_state_type state_ff, state_in;
   logic [7:0]     x_ff, x_in;
   logic [6:0]     y_ff, y_in;
   op_type         op_ff, op_in;
   logic [12:0]    here_ff, here_in;
   logic [12:0]    cnt_ff, cnt_in;
   logic [15:0]    cell_ff, cell_in;
   logic           pend_ff, pend_in;
   logic [12:0]    pend_addr_ff, pend_addr_in;

   logic [15:0]    mem [CELLS];
   logic [15:0]    rdata_ff;
   logic [CELL_AW-1:0] raddr;
   logic [CELL_AW-1:0] waddr;
   logic [15:0]    wdata;
   logic           we;

   logic [7:0]     nc;
   logic [6:0]     nr;
   logic [7:0]     nc_m1;
   logic [6:0]     nr_m1;
   logic [14:0]    lin_full;
   logic [13:0]    tab_addr;
   logic [12:0]    src_addr;
   logic [12:0]    blank_addr;
   logic [6:0]     y_next;
   logic           take;
   logic           lf_scroll;
   logic           scroll_more;

   assign nc    = geom.cols;
   assign nr    = geom.rows;
   assign nc_m1 = nc - 8'd1;
   assign nr_m1 = nr - 7'd1;

   assign lin_full    = 15'(y_ff) * 15'(nc) + 15'(x_ff);
   assign tab_addr    = 14'(here_ff) + 14'(cnt_ff);
   assign src_addr    = cnt_ff + 13'(nc);
   assign blank_addr  = geom.moved + cnt_ff;
   assign y_next      = y_ff + 7'd1;
   assign take        = !opq.empty && !rsp_full;
   assign lf_scroll   = (y_next >= nr_m1);
   assign scroll_more = (cnt_ff < geom.moved);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) state_in = ST_ADDR;
         end
         ST_ADDR: begin
            case (op_ff.kind)
               OP_LF:    state_in = lf_scroll ? ST_SCROLL : ST_OFFSET;
               OP_BS:    state_in = ST_EXEC;
               OP_PRINT: state_in = ST_EXEC;
               OP_TAB:   state_in = ST_TAB;
               OP_CLEAR: state_in = ST_CLEAR;
               OP_READ:  state_in = ST_READ;
               default:  state_in = ST_OFFSET;
            endcase
         end
         ST_EXEC: begin
            state_in = (op_ff.kind == OP_PRINT) ? ST_WRAP : ST_OFFSET;
         end
         ST_TAB: begin
            if (cnt_ff == 13'(TAB_WIDTH - 1)) state_in = ST_WRAP;
         end
         ST_WRAP: begin
            if (x_ff >= nc) begin
               state_in = ST_WRAP;
            end else if (y_ff >= nr) begin
               state_in = ST_SCROLL;
            end else begin
               state_in = ST_OFFSET;
            end
         end
         ST_SCROLL: begin
            if (!scroll_more) state_in = ST_BLANK;
         end
         ST_BLANK: begin
            if (cnt_ff == 13'(nc_m1)) state_in = ST_OFFSET;
         end
         ST_CLEAR: begin
            if ({1'b0, cnt_ff} == geom.total - 14'd1) state_in = ST_OFFSET;
         end
         ST_READ:   state_in = ST_OFFSET;
         ST_OFFSET: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      x_in         = x_ff;
      y_in         = y_ff;
      op_in        = op_ff;
      here_in      = here_ff;
      cnt_in       = cnt_ff;
      cell_in      = cell_ff;
      opq_pop      = 1'b0;
      pend_in      = 1'b0;
      pend_addr_in = cnt_ff;
      we           = 1'b0;
      waddr        = cnt_ff;
      wdata        = 16'd0;
      raddr        = op_ff.cell_index;
      rsp_wr.push  = 1'b0;
      rsp_wr.res   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               opq_pop = 1'b1;
               op_in   = opq.op;
               cell_in = 16'd0;
               // A cursor left beyond a changed geometry is pulled back.
               x_in    = (x_ff >= nc) ? nc_m1 : x_ff;
               y_in    = (y_ff >= nr) ? nr_m1 : y_ff;
            end
         end
         ST_ADDR: begin
            here_in = lin_full[12:0];
            cnt_in  = 13'd0;
            case (op_ff.kind)
               OP_CR: x_in = 8'd0;
               OP_LF: begin
                  x_in = 8'd0;
                  y_in = lf_scroll ? nr_m1 : y_next;
               end
               default: begin
               end
            endcase
         end
         ST_EXEC: begin
            if (op_ff.kind == OP_PRINT) begin
               we    = 1'b1;
               waddr = here_ff;
               wdata = {op_ff.attr, op_ff.ch};
               x_in  = x_ff + 8'd1;
            end else if (x_ff != 8'd0) begin
               we    = 1'b1;
               waddr = here_ff - 13'd1;
               wdata = {op_ff.attr, CH_NUL};
               x_in  = x_ff - 8'd1;
            end
         end
         ST_TAB: begin
            // Blanking stops at the last cell of the screen.
            if (tab_addr < geom.total) begin
               we    = 1'b1;
               waddr = tab_addr[12:0];
               wdata = {op_ff.attr, CH_NUL};
            end
            if (cnt_ff == 13'(TAB_WIDTH - 1)) begin
               x_in = x_ff + 8'(TAB_WIDTH);
            end else begin
               cnt_in = cnt_ff + 13'd1;
            end
         end
         ST_WRAP: begin
            if (x_ff >= nc) begin
               x_in = x_ff - nc;
               y_in = y_ff + 7'd1;
            end else if (y_ff >= nr) begin
               y_in   = nr_m1;
               cnt_in = 13'd0;
            end
         end
         ST_SCROLL: begin
            // Read one row ahead; the cell lands in the next cycle.
            raddr = src_addr;
            if (scroll_more) begin
               pend_in      = 1'b1;
               pend_addr_in = cnt_ff;
               cnt_in       = cnt_ff + 13'd1;
            end else begin
               cnt_in = 13'd0;
            end
         end
         ST_BLANK: begin
            we     = 1'b1;
            waddr  = blank_addr;
            wdata  = {geom.blank_attr, CH_NUL};
            cnt_in = cnt_ff + 13'd1;
         end
         ST_CLEAR: begin
            we     = 1'b1;
            waddr  = cnt_ff;
            wdata  = {op_ff.attr, CH_NUL};
            cnt_in = cnt_ff + 13'd1;
            if ({1'b0, cnt_ff} == geom.total - 14'd1) begin
               x_in = 8'd0;
               y_in = 7'd0;
            end
         end
         ST_READ: begin
            cell_in = rdata_ff;
         end
         ST_OFFSET: begin
            rsp_wr.push              = 1'b1;
            rsp_wr.res.cursor_col    = x_ff[6:0];
            rsp_wr.res.cursor_row    = y_ff[5:0];
            rsp_wr.res.cursor_offset = lin_full[12:0];
            rsp_wr.res.cell_char     = cell_ff[7:0];
            rsp_wr.res.cell_attr     = cell_ff[15:8];
         end
         default: begin
         end
      endcase

      // The delayed scroll write owns the port when it is due.
      if (pend_ff) begin
         we    = 1'b1;
         waddr = pend_addr_ff;
         wdata = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         x_ff     <= 8'd0;
         y_ff     <= 7'd0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      here_ff      <= here_in;
      cnt_ff       <= cnt_in;
      cell_ff      <= cell_in;
      pend_addr_ff <= pend_addr_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

endmodule

### hw/rtl/tccu_rsp_queue.sv
// Two-entry result queue that parts the back end from the result channel.
module tccu_rsp_queue import tccu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  rsp_write_type wr,
   input  logic          pop,
   output logic          empty,
   output logic          full,
   output result_type    head
);

   result_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign empty   = (count_ff == 2'd0);
   assign full    = (count_ff == 2'd2);
   assign do_push = wr.push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= wr.res;
      end
   end

   assign head = q_ff[rd_ptr_ff];

endmodule

### hw/rtl/text_console_cursor_engine_unit.sv
// Top level of the text console cursor engine: registers, front, back and result queue.
//
// Items enter through a queue-like port: a beat is taken when req_push is high and
// req_full is low. Each item gives exactly one result beat, read from a queue-like
// port: the oldest result is on the rsp_ ports while rsp_empty is low, and a beat
// leaves when rsp_pop is high. The csr_ channel is always ready; index 0 sets the
// columns, 1 the rows and 2 the attribute of the line blanked by a scroll. Out of
// range geometry is pulled into range as it is written. The user must write the
// registers only while no item is in flight; the block itself does not enforce it.
// A two-entry queue holds classified items in front of the sequencer, so the port
// keeps taking beats while the sequencer works. The sequencer runs one item at a
// time, from the idle state through an address state and the work states of the item
// (exec, tab, wrap, scroll, blank, clear or read) to the offset state that pushes
// the result. The screen store takes one cell per cycle and so sets the long cases:
// a clear writes every cell of the screen, and a scroll copies columns * (rows - 1)
// cells up one row and then blanks the last row.
// A stalled receiver fills the two-entry result queue; the sequencer then holds its
// next item and the input queue fills behind it, raising req_full.
// Reset empties both queues, homes the cursor and loads the default geometry of 80 by
// 25 with attribute 7; the screen store is not cleared and reads garbage until written.
module text_console_cursor_engine_unit import tccu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Input items
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_ch,
   input  logic [7:0]  req_attr,
   input  logic [12:0] req_cell_index,
   // Results
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [6:0]  rsp_cursor_col,
   output logic [5:0]  rsp_cursor_row,
   output logic [12:0] rsp_cursor_offset,
   output logic [7:0]  rsp_cell_char,
   output logic [7:0]  rsp_cell_attr,
   // Configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   logic [7:0]     cols_ff, cols_in;
   logic [6:0]     rows_ff, rows_in;
   logic [7:0]     blank_ff, blank_in;
   logic [13:0]    total_ff;
   logic [12:0]    moved_ff;
   logic [14:0]    total_full;
   logic [6:0]     rows_raw;
   logic           csr_write;
   geom_type       geom;
   opq_status_type opq;
   logic           opq_pop;
   logic           rsp_full;
   rsp_write_type  rsp_wr;
   result_type     head;

   // The channel never stalls, so a write completes whenever valid is high.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign rows_raw  = csr_data[6:0];

   // Geometry is clamped as it is written, so the back end only ever sees legal sizes.
   always_comb begin
      cols_in  = cols_ff;
      rows_in  = rows_ff;
      blank_in = blank_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_COLUMNS: begin
               if (csr_data == 8'd0) begin
                  cols_in = 8'd1;
               end else if (csr_data > 8'(MAX_COLS)) begin
                  cols_in = 8'(MAX_COLS);
               end else begin
                  cols_in = csr_data;
               end
            end
            CSR_ROWS: begin
               if (rows_raw < 7'd2) begin
                  rows_in = 7'd2;
               end else if (rows_raw > 7'(MAX_ROWS)) begin
                  rows_in = 7'(MAX_ROWS);
               end else begin
                  rows_in = rows_raw;
               end
            end
            CSR_BLANK: blank_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   // Screen size and the length of a scroll copy, kept in registers that follow the
   // geometry registers and update in the cycle after them; an item reaches the sequencer later than that.
   assign total_full = 15'(cols_ff) * 15'(rows_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= COLUMNS_RESET;
         rows_ff  <= ROWS_RESET;
         blank_ff <= BLANK_RESET;
         total_ff <= 14'(COLUMNS_RESET) * 14'(ROWS_RESET);
         moved_ff <= 13'(COLUMNS_RESET) * 13'(ROWS_RESET - 7'd1);
      end else begin
         cols_ff  <= cols_in;
         rows_ff  <= rows_in;
         blank_ff <= blank_in;
         total_ff <= total_full[13:0];
         moved_ff <= total_full[12:0] - 13'(cols_ff);
      end
   end

   assign geom = '{cols: cols_ff, rows: rows_ff, blank_attr: blank_ff,
                   total: total_ff, moved: moved_ff};

   tccu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .cmd        (req_cmd),
      .ch         (req_ch),
      .attr       (req_attr),
      .cell_index (req_cell_index),
      .pop        (opq_pop),
      .status     (opq)
   );

   tccu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .geom     (geom),
      .opq      (opq),
      .opq_pop  (opq_pop),
      .rsp_full (rsp_full),
      .rsp_wr   (rsp_wr)
   );

   tccu_rsp_queue u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .wr    (rsp_wr),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .full  (rsp_full),
      .head  (head)
   );

   assign rsp_cursor_col    = head.cursor_col;
   assign rsp_cursor_row    = head.cursor_row;
   assign rsp_cursor_offset = head.cursor_offset;
   assign rsp_cell_char     = head.cell_char;
   assign rsp_cell_attr     = head.cell_attr;

   // The sequencer only starts an item when the result queue has room, so a result
   // is never pushed into a full queue.
   a_no_rsp_overflow : assert property (@(posedge clock) disable iff (reset)
      rsp_wr.push |-> !rsp_full)
      else $error("result pushed into a full result queue");

   // An accepted beat is waiting for the sequencer in the next cycle.
   a_item_queued : assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> !opq.empty)
      else $error("accepted item missing from the input queue");

   // One item gives one result: two pushes never come back to back.
   a_single_result : assert property (@(posedge clock) disable iff (reset)
      rsp_wr.push |=> !rsp_wr.push)
      else $error("result pushed twice for one item");

endmodule

### tb/sv/tb.sv
// Self-checking testbench of the text console cursor engine, driven and checked through queues.
`timescale 1ns / 100ps

module tb import tccu_pkg::*; ();

   // The fourth command code has no meaning in the block; it must behave like a put of NUL.
   localparam logic [1:0] CMD_SPARE = 2'd3;
   // Rough number of items to send before the stimulus stops.
   localparam int ITEM_TARGET = 950;
   // Mismatch lines beyond this many are counted but not printed.
   localparam int PRINT_CAP = 100;
   // Hard stop for a hung run, far beyond the slowest correct run.
   localparam int LIMIT_NS = 100_000_000;

   // One pending item together with the result that it must produce.
   typedef struct {
      logic [1:0]  cmd;
      logic [7:0]  ch;
      logic [7:0]  attr;
      logic [12:0] cell_index;
      bit          drain;
      result_type  want;
   } console_item_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_cmd = CMD_PUT;
   logic [7:0]  req_ch = CH_NUL;
   logic [7:0]  req_attr = 8'h00;
   logic [12:0] req_cell_index = 13'h0000;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [6:0]  rsp_cursor_col;
   logic [5:0]  rsp_cursor_row;
   logic [12:0] rsp_cursor_offset;
   logic [7:0]  rsp_cell_char;
   logic [7:0]  rsp_cell_attr;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_COLUMNS;
   logic [7:0]  csr_data = 8'h00;

   text_console_cursor_engine_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_cmd           (req_cmd),
      .req_ch            (req_ch),
      .req_attr          (req_attr),
      .req_cell_index    (req_cell_index),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_cursor_col    (rsp_cursor_col),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_offset (rsp_cursor_offset),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_cell_attr     (rsp_cell_attr),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // Shadow copy of the screen. Alongside every cell we track whether it has ever been
   // written, since the block's store holds garbage until then and such cells must never
   // be read back. Scrolls carry that knowledge along with the cells they move.
   logic [15:0] shadow_cells [CELLS];
   bit          cell_known [CELLS];
   int unsigned cur_x;
   int unsigned cur_y;
   int unsigned cfg_cols;
   int unsigned cfg_rows;
   int unsigned cfg_blank;

   // Items waiting for the driver, and results owed by the block for accepted beats.
   console_item_type pending_items[$];
   result_type       awaited_results[$];
   console_item_type bus_item;

   bit          driving = 1'b0;
   bit          req_taken = 1'b0;
   bit          pop_taken = 1'b0;
   bit          send_steady = 1'b0;
   bit          pop_steady = 1'b0;
   int unsigned send_gap = 0;
   int unsigned pop_stall = 0;
   int unsigned items_queued = 0;
   int unsigned rsp_beats = 0;
   int unsigned mismatch_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("text_console_cursor_engine_unit verification failed");
      $finish;
   end

   // Geometry in use: register values outside the legal range act as the nearest limit.
   function automatic int unsigned screen_cols();
      if (cfg_cols == 0) return 1;
      if (cfg_cols > MAX_COLS) return MAX_COLS;
      return cfg_cols;
   endfunction

   function automatic int unsigned screen_rows();
      if (cfg_rows < 2) return 2;
      if (cfg_rows > MAX_ROWS) return MAX_ROWS;
      return cfg_rows;
   endfunction

   function automatic void write_cell(int unsigned idx, logic [7:0] c, logic [7:0] a);
      if (idx < CELLS) begin
         shadow_cells[idx] = {a, c};
         cell_known[idx] = 1'b1;
      end
   endfunction

   // Every row but the first moves up by one, and the freed last row is blanked.
   function automatic void shift_screen(int unsigned nc, int unsigned nr);
      int unsigned moved;
      moved = nc * (nr - 1);
      for (int unsigned i = 0; i < moved; i++) begin
         shadow_cells[i] = shadow_cells[i + nc];
         cell_known[i] = cell_known[i + nc];
      end
      for (int unsigned i = 0; i < nc; i++) write_cell(moved + i, CH_NUL, cfg_blank[7:0]);
   endfunction

   // Applies one item to the shadow screen and cursor, and returns the result beat that the
   // block must give for it.
   function automatic result_type apply_console_item(logic [1:0] cmd, logic [7:0] ch,
                                                    logic [7:0] attr, logic [12:0] idx);
      int unsigned nc;
      int unsigned nr;
      int unsigned total;
      int unsigned here;
      int unsigned offset;
      result_type  res;
      nc = screen_cols();
      nr = screen_rows();
      total = nc * nr;
      res = '0;
      // A cursor left beyond a smaller geometry is pulled back to the last column or row.
      if (cur_x >= nc) cur_x = nc - 1;
      if (cur_y >= nr) cur_y = nr - 1;
      case (cmd)
         CMD_PUT: begin
            here = cur_y * nc + cur_x;
            case (ch)
               CH_NUL: ;
               CH_CR: cur_x = 0;
               CH_LF: begin
                  cur_x = 0;
                  cur_y++;
                  if (cur_y >= nr - 1) begin
                     shift_screen(nc, nr);
                     cur_y = nr - 1;
                  end
               end
               CH_BS: begin
                  if (cur_x != 0) begin
                     cur_x--;
                     write_cell(here - 1, CH_NUL, attr);
                  end
               end
               CH_TAB: begin
                  // Blanking never runs past the last cell of the screen.
                  for (int unsigned i = 0; i < TAB_WIDTH && here + i < total; i++)
                     write_cell(here + i, CH_NUL, attr);
                  cur_x += TAB_WIDTH;
               end
               default: begin
                  write_cell(here, ch, attr);
                  cur_x++;
               end
            endcase
            if (cur_x >= nc) begin
               cur_y += cur_x / nc;
               cur_x = cur_x % nc;
            end
            if (cur_y >= nr) begin
               shift_screen(nc, nr);
               cur_y = nr - 1;
            end
         end
         CMD_CLEAR: begin
            for (int unsigned i = 0; i < total; i++) write_cell(i, CH_NUL, attr);
            cur_x = 0;
            cur_y = 0;
         end
         CMD_READ: begin
            res.cell_char = shadow_cells[idx][7:0];
            res.cell_attr = shadow_cells[idx][15:8];
         end
         default: ;
      endcase
      offset = cur_y * nc + cur_x;
      res.cursor_col = cur_x[6:0];
      res.cursor_row = cur_y[5:0];
      res.cursor_offset = offset[12:0];
      return res;
   endfunction

   function automatic int unsigned idle_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("[%0t] result beat %0d: %s is %0d, expected %0d",
                  $time, rsp_beats, what, got, want);
   endtask

   // The prediction is made as the item is queued; since the driver keeps queue order,
   // the shadow state always follows the order in which the block accepts the beats.
   task automatic queue_item(input logic [1:0] cmd, input logic [7:0] ch,
                             input logic [7:0] attr, input logic [12:0] idx,
                             input bit drain = 1'b0);
      console_item_type it;
      it.cmd = cmd;
      it.ch = ch;
      it.attr = attr;
      it.cell_index = idx;
      it.drain = drain;
      it.want = apply_console_item(cmd, ch, attr, idx);
      pending_items.push_back(it);
      items_queued++;
   endtask

   // Mostly text with a fair share of control characters, plus reads of cells that are
   // known to hold data, and the odd clear or unused command.
   task automatic queue_random_item();
      int unsigned pick;
      int unsigned total;
      int unsigned idx;
      int unsigned tries;
      bit          found;
      bit          drain;
      logic [7:0]  ch;
      pick = $urandom_range(0, 99);
      drain = ($urandom_range(0, 79) == 0);
      if (pick < 2) begin
         queue_item(CMD_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    13'($urandom_range(0, CELLS - 1)), drain);
      end else if (pick < 4) begin
         queue_item(CMD_SPARE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    13'($urandom_range(0, CELLS - 1)), drain);
      end else if (pick < 20) begin
         total = screen_cols() * screen_rows();
         found = 1'b0;
         idx = 0;
         for (tries = 0; tries < 16 && !found; tries++) begin
            idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, CELLS - 1)
                                              : $urandom_range(0, total - 1);
            found = cell_known[idx];
         end
         if (found)
            queue_item(CMD_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       idx[12:0], drain);
         else
            queue_item(CMD_PUT, 8'($urandom_range(8'h20, 8'hFF)),
                       8'($urandom_range(0, 255)), 13'($urandom_range(0, CELLS - 1)),
                       drain);
      end else begin
         case ($urandom_range(0, 19))
            0:       ch = CH_NUL;
            1:       ch = CH_CR;
            2, 3:    ch = CH_LF;
            4:       ch = CH_BS;
            5:       ch = CH_TAB;
            default: ch = 8'($urandom_range(0, 255));
         endcase
         queue_item(CMD_PUT, ch, 8'($urandom_range(0, 255)),
                    13'($urandom_range(0, CELLS - 1)), drain);
      end
   endtask

   // Register writes happen only with the block idle. The shadow configuration follows the
   // write once the beat has been taken.
   task automatic write_csr(input logic [1:0] idx, input logic [7:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_COLUMNS: cfg_cols = 32'(data);
         CSR_ROWS:    cfg_rows = 32'(data[6:0]);
         CSR_BLANK:   cfg_blank = 32'(data);
         default: ;
      endcase
   endtask

   // Waits until every queued item has gone in and every result beat has come out, and then
   // lets the block finish any trailing store work.
   task automatic settle();
      do @(negedge clock);
      while (pending_items.size() != 0 || driving || awaited_results.size() != 0);
      repeat (12) @(negedge clock);
   endtask

   // Input driver. A new beat is presented at the falling edge once the previous one has
   // been taken and its random gap has run out. An item marked for draining is held back
   // until every outstanding result beat has been collected.
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_taken) begin
            req_taken = 1'b0;
            driving = 1'b0;
         end
         if (!driving) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (pending_items.size() != 0 &&
                         !(pending_items[0].drain && awaited_results.size() != 0)) begin
               bus_item = pending_items.pop_front();
               req_cmd <= bus_item.cmd;
               req_ch <= bus_item.ch;
               req_attr <= bus_item.attr;
               req_cell_index <= bus_item.cell_index;
               driving = 1'b1;
               // Now and then switch into or out of a stretch with no gaps at all.
               if ($urandom_range(0, 47) == 0) send_steady = !send_steady;
               send_gap = send_steady ? 0 : idle_cycles();
            end
         end
         req_push <= driving;
      end
   end

   // Result side stalls. After each collected beat the pop line may drop for a while, so
   // that the result queue fills up and back-pressure reaches the input side.
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (pop_taken) begin
            pop_taken = 1'b0;
            if ($urandom_range(0, 47) == 0) pop_steady = !pop_steady;
            pop_stall = pop_steady ? 0 : idle_cycles();
         end
         if (pop_stall != 0) begin
            pop_stall--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Monitor. Both handshakes are sampled at the rising edge. A result beat is checked
   // before a same-cycle input beat is recorded, so that a spurious result can never be
   // matched against the item that has only just gone in.
   always @(posedge clock) begin : monitor
      result_type want;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            rsp_beats++;
            pop_taken = 1'b1;
            if (awaited_results.size() == 0) begin
               report_mismatch("beat with no result awaited, cursor_offset",
                               32'(rsp_cursor_offset), 0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_cursor_col !== want.cursor_col)
                  report_mismatch("cursor_col", 32'(rsp_cursor_col),
                                  32'(want.cursor_col));
               if (rsp_cursor_row !== want.cursor_row)
                  report_mismatch("cursor_row", 32'(rsp_cursor_row),
                                  32'(want.cursor_row));
               if (rsp_cursor_offset !== want.cursor_offset)
                  report_mismatch("cursor_offset", 32'(rsp_cursor_offset),
                                  32'(want.cursor_offset));
               if (rsp_cell_char !== want.cell_char)
                  report_mismatch("cell_char", 32'(rsp_cell_char), 32'(want.cell_char));
               if (rsp_cell_attr !== want.cell_attr)
                  report_mismatch("cell_attr", 32'(rsp_cell_attr), 32'(want.cell_attr));
            end
         end
         if (req_push && !req_full) begin
            awaited_results.push_back(bus_item.want);
            req_taken = 1'b1;
         end
      end
   end

   initial begin : stimulus
      static int unsigned wide_cols [5] = '{0, 128, 129, 200, 255};
      static int unsigned tall_rows [6] = '{0, 1, 64, 65, 100, 127};
      int unsigned cols_raw;
      int unsigned rows_raw;
      int unsigned sel;
      cfg_cols = 32'(COLUMNS_RESET);
      cfg_rows = 32'(ROWS_RESET);
      cfg_blank = 32'(BLANK_RESET);
      cur_x = 0;
      cur_y = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset geometry of 80 by 25. The screen is cleared first, as nothing may be read
      // before it has been written. Then every control character, including backspace at
      // the first column, the byte extremes, reads and the unused command.
      queue_item(CMD_CLEAR, 8'h00, 8'h1E, 13'h0000);
      queue_item(CMD_PUT, 8'h41, 8'h00, 13'h0000);
      queue_item(CMD_PUT, 8'hFF, 8'hFF, 13'h1FFF);
      queue_item(CMD_PUT, CH_NUL, 8'h55, 13'h0AAA);
      queue_item(CMD_PUT, CH_CR, 8'hAA, 13'h1555);
      queue_item(CMD_PUT, CH_BS, 8'h3C, 13'h0000);
      queue_item(CMD_PUT, CH_TAB, 8'h2B, 13'h0000);
      queue_item(CMD_PUT, CH_BS, 8'h5A, 13'h0000);
      queue_item(CMD_READ, 8'h00, 8'h00, 13'd0);
      queue_item(CMD_READ, 8'hFF, 8'hFF, 13'd7);
      queue_item(CMD_READ, 8'h00, 8'h00, 13'd1);
      queue_item(CMD_SPARE, 8'hFF, 8'hFF, 13'h1FFF);
      queue_item(CMD_PUT, CH_LF, 8'h00, 13'h0000);
      queue_item(CMD_PUT, 8'h7A, 8'hE1, 13'h0000);
      queue_item(CMD_READ, 8'h00, 8'h00, 13'd80, 1'b1);
      settle();

      // Largest geometry, reached through out-of-range values that must act as the limits.
      // After a full clear every cell of the store is known, so reads may go anywhere. The
      // feed is mostly line feeds, to get down to the last row and scroll the full screen.
      write_csr(CSR_COLUMNS, 8'hFF);
      write_csr(CSR_ROWS, 8'd127);
      write_csr(CSR_BLANK, 8'h00);
      queue_item(CMD_CLEAR, 8'h00, 8'hC3, 13'h0000);
      queue_item(CMD_READ, 8'h00, 8'h00, 13'h1FFF);
      queue_item(CMD_READ, 8'h00, 8'h00, 13'h0000);
      repeat (100) begin
         if ($urandom_range(0, 4) != 0)
            queue_item(CMD_PUT, CH_LF, 8'($urandom_range(0, 255)),
                       13'($urandom_range(0, CELLS - 1)));
         else
            queue_random_item();
      end
      settle();

      // One column and two rows, from values below the limits: every character wraps and
      // scrolls, and a tab runs into the end of the screen. The cursor arrives stale.
      write_csr(CSR_COLUMNS, 8'h00);
      write_csr(CSR_ROWS, 8'h00);
      write_csr(CSR_BLANK, 8'hFF);
      queue_item(CMD_PUT, 8'h61, 8'h12, 13'h0000);
      queue_item(CMD_PUT, CH_TAB, 8'h34, 13'h0000);
      queue_item(CMD_PUT, CH_LF, 8'h56, 13'h0000);
      queue_item(CMD_PUT, CH_BS, 8'h78, 13'h0000);
      queue_item(CMD_READ, 8'h00, 8'h00, 13'd0);
      queue_item(CMD_READ, 8'h00, 8'h00, 13'd1);
      settle();

      // Three columns on the smallest legal row count; the tab on the last row only blanks
      // what is left of the screen and then forces a scroll.
      write_csr(CSR_COLUMNS, 8'd3);
      write_csr(CSR_ROWS, 8'd1);
      write_csr(CSR_BLANK, 8'h81);
      queue_item(CMD_PUT, CH_LF, 8'h9A, 13'h0000);
      queue_item(CMD_PUT, 8'h71, 8'hBC, 13'h0000);
      queue_item(CMD_PUT, CH_TAB, 8'hDE, 13'h0000);
      queue_item(CMD_READ, 8'h00, 8'h00, 13'd3);
      queue_item(CMD_READ, 8'h00, 8'h00, 13'd5);
      settle();

      // Random phases. Geometry stays small for most of them so that scrolls and clears
      // stay cheap; now and then one dimension goes to or beyond its limit while the other
      // stays small. Half of the phases start without a clear, so the cursor may be stale.
      while (items_queued < ITEM_TARGET) begin
         sel = $urandom_range(0, 7);
         if (sel == 0) begin
            cols_raw = wide_cols[$urandom_range(0, 4)];
            rows_raw = $urandom_range(2, 6);
         end else if (sel == 1) begin
            cols_raw = $urandom_range(1, 6);
            rows_raw = tall_rows[$urandom_range(0, 5)];
         end else begin
            cols_raw = $urandom_range(1, 24);
            rows_raw = $urandom_range(2, 12);
         end
         write_csr(CSR_COLUMNS, cols_raw[7:0]);
         write_csr(CSR_ROWS, rows_raw[7:0]);
         write_csr(CSR_BLANK, 8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1) == 0)
            queue_item(CMD_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       13'($urandom_range(0, CELLS - 1)));
         repeat ($urandom_range(30, 80)) queue_random_item();
         settle();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0)
         $display("text_console_cursor_engine_unit verification clean");
      else
         $display("text_console_cursor_engine_unit verification failed");
      $finish;
   end

endmodule
